>>> rtl/core/rbpc_pkg.sv
package rbpc_pkg;

   // Number of cells in the chain, and so the longest sequence that is ranked
   localparam int MAX_ITEMS = 64;

   localparam int VALUE_W  = 32;
   localparam int RANK_W   = 6;
   localparam int DIGITS_W = 3;
   localparam int COUNT_W  = 7;

   // Request token walking down the chain
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic [RANK_W-1:0]         acc;    // older values found smaller so far
   } token_type;

   // Cell contents seen by the upper neighbor during unload
   typedef struct packed {
      logic              occ;
      logic [RANK_W-1:0] count;
   } cell_state_type;

   // Binary digit count of v, at least one
   function automatic logic [DIGITS_W-1:0] digits_of(input logic [RANK_W-1:0] v);
      logic [DIGITS_W-1:0] w;
      w = DIGITS_W'(1);
      for (int i = 1; i < RANK_W; i++) begin
         if (v[i]) w = DIGITS_W'(i + 1);
      end
      return w;
   endfunction

endpackage

>>> rtl/core/rbpc_cell.sv
module rbpc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rbpc_pkg::token_type      up_tok,    // token from the upper neighbor
   output rbpc_pkg::token_type      down_tok,  // token handed to the lower neighbor
   input  logic                    shift_en,  // unload: take the lower neighbor's state
   input  rbpc_pkg::cell_state_type up_state,
   output rbpc_pkg::cell_state_type cell_state
);

   logic                                occ_ff, occ_in;
   logic signed [rbpc_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [rbpc_pkg::RANK_W-1:0]         count_ff, count_in;
   rbpc_pkg::token_type                 tok_ff, tok_in;

   // Shift in on unload, else compare token to stored value or take it if empty
   always_comb begin
      occ_in       = occ_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      tok_in       = up_tok;
      tok_in.valid = 1'b0;
      if (shift_en) begin
         occ_in   = up_state.occ;
         count_in = up_state.count;
      end else if (up_tok.valid) begin
         if (occ_ff) begin
            tok_in.valid = 1'b1;
            if (value_ff < up_tok.value) begin
               tok_in.acc = up_tok.acc + rbpc_pkg::RANK_W'(1);
            end else if (value_ff > up_tok.value) begin
               count_in = count_ff + rbpc_pkg::RANK_W'(1);
            end
         end else begin
            occ_in   = 1'b1;
            value_in = up_tok.value;
            count_in = up_tok.acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         occ_ff   <= occ_in;
         value_ff <= value_in;
         count_ff <= count_in;
         tok_ff   <= tok_in;
      end
   end

   assign down_tok         = tok_ff;
   assign cell_state.occ   = occ_ff;
   assign cell_state.count = count_ff;

endmodule

>>> rtl/core/rank_by_pairwise_count.sv
// Ranks a sequence of signed 32-bit values: each request loads one value; the
// request with tlast closes the sequence. Each value enters a chain of 64 cells
// and moves one cell per cycle; every loaded cell it passes adds one to its own
// count (stored value larger) or to the token's count (stored value smaller),
// or to neither on a tie; the token settles in the first empty cell. Requests
// are taken one per cycle while loading. After the closing request the block
// waits for the last token to settle, then emits one response per loaded value
// in load order, one per cycle while rsp_tready allows, by shifting the cells
// toward the output; no request is taken until the last response has left the
// chain. Each response carries the rank, the digit count of the number of
// loaded values minus 1 (at least 1), tlast on the final value, and an overflow
// flag in tuser if values beyond 64 were dropped. Tied values share a rank.
module rank_by_pairwise_count (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value (signed)
   input  logic        req_tlast,   // last_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] rank, [8:6] digits, [15:9] zero
   output logic        rsp_tlast,   // last_rank
   output logic        rsp_tuser    // overflow
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   localparam int N = rbpc_pkg::MAX_ITEMS;
   localparam int CW = rbpc_pkg::COUNT_W;

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 item_count_ff, item_count_in;
   logic                          dropped_ff, dropped_in;
   logic [rbpc_pkg::DIGITS_W-1:0] digits_ff, digits_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rbpc_pkg::RANK_W-1:0]   rsp_rank_ff, rsp_rank_in;
   logic [rbpc_pkg::DIGITS_W-1:0] rsp_digits_ff, rsp_digits_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   rbpc_pkg::token_type      tok_link [0:N];
   rbpc_pkg::cell_state_type st_link  [0:N];

   logic req_accept;
   logic room;
   logic inflight;
   logic emit_load;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign room       = (item_count_ff < CW'(N));
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Token entering the head of the chain
   always_comb begin
      tok_link[0].valid = req_accept && room;
      tok_link[0].value = req_tdata;
      tok_link[0].acc   = '0;
   end

   assign st_link[N] = '0;

   // Row of cells
   for (genvar k = 0; k < N; k++) begin : g_cell
      rbpc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_tok     (tok_link[k]),
         .down_tok   (tok_link[k+1]),
         .shift_en   (emit_load),
         .up_state   (st_link[k+1]),
         .cell_state (st_link[k])
      );
   end

   // Any token still walking the chain
   always_comb begin
      inflight = 1'b0;
      for (int k = 1; k <= N; k++) begin
         inflight = inflight | tok_link[k].valid;
      end
   end

   // Sequence control
   always_comb begin
      state_in      = state_ff;
      item_count_in = item_count_ff;
      dropped_in    = dropped_ff;
      digits_in     = digits_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (room) item_count_in = item_count_ff + CW'(1);
               else      dropped_in    = 1'b1;
               if (req_tlast) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!inflight) begin
               digits_in = rbpc_pkg::digits_of(
                  rbpc_pkg::RANK_W'(item_count_ff - CW'(1)));
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               item_count_in = item_count_ff - CW'(1);
               if (item_count_ff == CW'(1)) begin
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Response register, loaded from the head cell
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_rank_in   = rsp_rank_ff;
      rsp_digits_in = rsp_digits_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (emit_load) begin
         rsp_valid_in  = 1'b1;
         rsp_rank_in   = st_link[0].count;
         rsp_digits_in = digits_ff;
         rsp_last_in   = (item_count_ff == CW'(1));
         rsp_ovf_in    = dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         item_count_ff <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_count_ff <= item_count_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff     <= digits_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_digits_ff <= rsp_digits_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_digits_ff, rsp_rank_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

`ifndef SYNTHESIS
   // Fill count never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      item_count_ff <= CW'(N))
      else $error("item count beyond capacity");

   // No token walks the chain while cells are being unloaded
   a_no_token_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !inflight)
      else $error("token in flight during unload");

   // Head cell holds a loaded value whenever one is still owed
   a_head_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> st_link[0].occ)
      else $error("head cell empty during unload");

   // After the final value leaves, the chain is empty
   a_chain_empty: assert property (@(posedge clock) disable iff (reset)
      (emit_load && item_count_ff == CW'(1)) |=> !st_link[0].occ)
      else $error("cells left loaded after final response");

   // Closing request moves control out of loading
   a_close_seq: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (state_ff == ST_DRAIN))
      else $error("closing request did not end loading");
`endif

endmodule
